>>> rtl/lurt_pkg.sv
// ----------------------------------------------------------------------------
// lurt_pkg: shared types and constants for the longest unique run tracker
// Item and result layouts, alphabet and position bounds.
// ----------------------------------------------------------------------------
package lurt_pkg;

    localparam int ALPHABET_SIZE     = 128;
    localparam int CODE_W            = $clog2(ALPHABET_SIZE);
    localparam int POS_W             = 16;
    localparam int LEN_W             = 7;
    localparam int MAX_STRING_LENGTH = 65536;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [POS_W-1:0] POS_LAST = {POS_W{1'b1}};

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic [6:0] symbol;
        logic       first_of_string;
    } in_item_t;

    typedef struct packed {
        len_t best_length;
        pos_t best_start;
        len_t window_length;
        logic position_overflow;
    } out_item_t;

endpackage

>>> rtl/lurt_stream_if.sv
// ----------------------------------------------------------------------------
// lurt_stream_if: valid/ready stream channel
// One transfer when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface lurt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/longest_unique_run_tracker_top.sv
// ----------------------------------------------------------------------------
// longest_unique_run_tracker_top: longest run of distinct characters
// Sliding window over a character stream with a last-position table.
//
//   channel  direction  payload
//   item     in         symbol, first_of_string
//   result   out        best_length, best_start, window_length,
//                       position_overflow
//
// One item per cycle sustained while result does not stall. The stage 1
// register reads the last-position memory (registered read port), then the
// work stage does the window update and loads the result register.
// Reset clears the valid marks and window records; the last-position memory
// is not cleared, an entry is only used while its valid mark is set.
// A stalled result holds the pipeline; item.ready drops only when both
// the work stage and the result register are occupied and result stalls.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker_top (
    input  logic              clk,
    input  logic              rst_n,
    lurt_stream_if.sink       item,
    lurt_stream_if.source     result
);

    // stage 1: item waiting for table data
    logic                 s1_valid_reg;
    lurt_pkg::code_t      s1_code_reg;
    logic                 s1_first_reg;
    lurt_pkg::pos_t       rd_reg;
    logic                 fwd_hit_reg;
    lurt_pkg::pos_t       fwd_pos_reg;

    // tracker state
    logic [lurt_pkg::ALPHABET_SIZE-1:0] seen_valid_reg;
    logic [lurt_pkg::ALPHABET_SIZE-1:0] seen_valid_next;
    lurt_pkg::pos_t       window_start_reg;
    lurt_pkg::pos_t       cur_pos_reg;
    lurt_pkg::len_t       longest_len_reg;
    lurt_pkg::pos_t       longest_start_reg;
    logic                 overflow_reg;

    lurt_pkg::pos_t       last_pos_mem [lurt_pkg::ALPHABET_SIZE];

    // result register
    logic                 out_valid_reg;
    lurt_pkg::out_item_t  out_data_reg;

    logic                 accept;
    logic                 adv;
    lurt_pkg::code_t      in_code;

    // work stage combinational logic
    lurt_pkg::pos_t       pos;
    lurt_pkg::pos_t       ws_base;
    lurt_pkg::len_t       best_len_base;
    lurt_pkg::pos_t       best_start_base;
    logic                 ovf_base;
    logic                 ovf_now;
    lurt_pkg::pos_t       last_pos;
    logic                 seen;
    logic                 repeat_hit;
    lurt_pkg::pos_t       ws_next;
    lurt_pkg::pos_t       run_diff;
    logic [lurt_pkg::POS_W:0] run_len_wide;
    lurt_pkg::len_t       run_len;
    logic                 new_best;
    lurt_pkg::len_t       best_len_next;
    lurt_pkg::pos_t       best_start_next;

    assign adv        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || adv;
    assign accept     = item.valid && item.ready;
    assign in_code    = lurt_pkg::CODE_W'(item.data.symbol);

    always_comb
    begin
        // a string start wipes all records before its own item is handled
        pos             = s1_first_reg ? '0 : cur_pos_reg;
        ws_base         = s1_first_reg ? '0 : window_start_reg;
        best_len_base   = s1_first_reg ? '0 : longest_len_reg;
        best_start_base = s1_first_reg ? '0 : longest_start_reg;
        ovf_base        = s1_first_reg ? 1'b0 : overflow_reg;
        ovf_now         = ovf_base || (32'(pos) >= 32'(lurt_pkg::MAX_STRING_LENGTH));

        seen       = !s1_first_reg && seen_valid_reg[s1_code_reg];
        last_pos   = fwd_hit_reg ? fwd_pos_reg : rd_reg;
        repeat_hit = seen && (last_pos >= ws_base);
        ws_next    = repeat_hit ? last_pos + lurt_pkg::POS_W'(1) : ws_base;

        run_diff     = pos - ws_next;
        run_len_wide = {1'b0, run_diff} + (lurt_pkg::POS_W+1)'(1);
        run_len      = (run_len_wide > (lurt_pkg::POS_W+1)'(lurt_pkg::LEN_MAX))
                       ? lurt_pkg::LEN_MAX : run_len_wide[lurt_pkg::LEN_W-1:0];

        new_best        = run_len > best_len_base;
        best_len_next   = new_best ? run_len : best_len_base;
        best_start_next = new_best ? ws_next : best_start_base;

        seen_valid_next = s1_first_reg ? '0 : seen_valid_reg;
        seen_valid_next[s1_code_reg] = 1'b1;
    end

    // last-position table: written by the work stage, read at transfer
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_pos_mem[s1_code_reg] <= pos;
        end
        if (accept)
        begin
            rd_reg <= last_pos_mem[in_code];
        end
    end

    // bypass for a write landing in the same cycle as the read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_pos_reg <= pos;
            s1_code_reg <= in_code;
            s1_first_reg <= item.data.first_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= adv && (s1_code_reg == in_code);
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_valid_reg    <= '0;
            window_start_reg  <= '0;
            cur_pos_reg       <= '0;
            longest_len_reg   <= '0;
            longest_start_reg <= '0;
            overflow_reg      <= 1'b0;
        end
        else if (adv)
        begin
            seen_valid_reg    <= seen_valid_next;
            window_start_reg  <= ws_next;
            cur_pos_reg       <= pos + lurt_pkg::POS_W'(1);
            longest_len_reg   <= best_len_next;
            longest_start_reg <= best_start_next;
            // counter wrap after the last position also flags overflow
            overflow_reg      <= ovf_now || (pos == lurt_pkg::POS_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.best_length       <= best_len_next;
            out_data_reg.best_start        <= best_start_next;
            out_data_reg.window_length     <= run_len;
            out_data_reg.position_overflow <= ovf_now;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule
